// ===== src/bdfw_pkg.sv =====
// shared types, register codes and constants of the bmp framebuffer writer
// used by every module under src
package bdfw_pkg;

    localparam int HEADER_BYTES      = 54;
    localparam int DEF_SCREEN_WIDTH  = 800;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_QUEUE_DEPTH   = 4;

    localparam int DIV_W      = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    // register reset values
    localparam logic [9:0] RST_SRC_WIDTH  = 10'd800;
    localparam logic [8:0] RST_SRC_HEIGHT = 9'd480;
    localparam logic [9:0] RST_DST_WIDTH  = 10'd800;
    localparam logic [8:0] RST_DST_HEIGHT = 9'd480;
    localparam logic [9:0] RST_STEP_X     = 10'd1;
    localparam logic [8:0] RST_STEP_Y     = 9'd1;
    localparam logic [9:0] RST_POS_X      = 10'd0;
    localparam logic [8:0] RST_POS_Y      = 9'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 4'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [18:0] write_address;
        logic [23:0] pixel_value;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [9:0] src_width;
        logic [8:0] src_height;
        logic [9:0] dst_width;
        logic [8:0] dst_height;
        logic [9:0] step_x;
        logic [8:0] step_y;
        logic [9:0] pos_x;
        logic [8:0] pos_y;
    } t_cfg;

    // kept pixel on its way from front to back
    typedef struct packed {
        logic [8:0]  orow;
        logic [9:0]  ocol;
        logic [23:0] pixel;
        logic        last;
    } t_pix;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== src/bdfw_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on bdfw_pkg
module bdfw_div import bdfw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_rem  <= '0;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_cnt  <= CNT_W'(DIV_W);
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_num  <= {r_num[DIV_W-2:0], w_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
            r_run  <= r_cnt != CNT_W'(1);
            r_done <= r_cnt == CNT_W'(1);
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run))
        else $error("divider done without a preceding run");

endmodule

// ===== src/bdfw_queue.sv =====
// short queue of kept pixels between the byte parser and the address stage
// depends on bdfw_pkg
module bdfw_queue import bdfw_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pix,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_pix o_pix
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pix             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_pix   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) |-> !i_push)
        else $error("push into a full pixel queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("pop from an empty pixel queue");

endmodule

// ===== src/bdfw_front.sv =====
// byte parser: header skip, bgr packing, row padding, row flip and decimation
// depends on bdfw_pkg and bdfw_div
module bdfw_front import bdfw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_cfg_valid,
    input  logic     i_cfg_wr,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    output logic     o_busy,
    output logic     o_push,
    output t_pix     o_pix,
    input  logic     i_q_full
);

    // quotient refresh sequence
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    localparam logic [5:0] HDR = 6'(HEADER_BYTES);

    logic [2:0]  r_state;
    logic        r_start;
    logic [5:0]  r_header_count;
    logic [11:0] r_row_byte_count;
    logic [8:0]  r_file_row;
    logic [7:0]  r_blue_hold;
    logic [7:0]  r_green_hold;
    logic [1:0]  r_byte_phase;
    logic [9:0]  r_pixel_column;
    // image row and column kept as quotient and remainder of their step
    logic [8:0]  r_row_q;
    logic [8:0]  r_row_r;
    logic [9:0]  r_col_q;
    logic [9:0]  r_col_r;
    logic [9:0]  r_jl;
    logic [9:0]  r_clast;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [9:0]  w_sx;
    logic [8:0]  w_sy;
    logic [11:0] w_data_len;
    logic [11:0] w_row_len;
    logic [11:0] w_rbc_inc;
    logic [8:0]  w_f;
    logic        w_accept;
    logic        w_active;
    logic        w_in_data;
    logic        w_keep;
    logic [9:0]  w_dst_w_m1;
    logic [9:0]  w_jl_cap;
    logic [19:0] w_clast_prod;
    logic [9:0]  w_col_r_inc;

    assign w_sx       = (i_cfg.step_x == '0) ? 10'd1 : i_cfg.step_x;
    assign w_sy       = (i_cfg.step_y == '0) ? 9'd1 : i_cfg.step_y;
    assign w_data_len = 12'(i_cfg.src_width) * 12'd3;
    assign w_row_len  = (w_data_len + 12'd3) & ~12'd3;
    assign w_rbc_inc  = r_row_byte_count + 12'd1;
    assign w_f        = i_cfg.src_height - 9'd1 - r_file_row;

    assign o_busy   = r_state != S_IDLE;
    assign o_stall  = o_busy || i_q_full || i_cfg_valid;
    assign w_accept = i_valid && !o_stall;

    assign w_active  = (r_header_count == HDR) && (i_cfg.src_width != '0)
                     && (i_cfg.src_height != '0) && (r_file_row < i_cfg.src_height);
    assign w_in_data = r_row_byte_count < w_data_len;
    assign w_keep    = (r_row_r == '0) && (r_row_q < i_cfg.dst_height)
                     && (r_col_r == '0) && (r_col_q < i_cfg.dst_width);

    assign w_col_r_inc = r_col_r + 10'd1;

    assign w_dst_w_m1   = i_cfg.dst_width - 10'd1;
    assign w_jl_cap     = (r_jl > w_dst_w_m1) ? w_dst_w_m1 : r_jl;
    assign w_clast_prod = w_jl_cap * w_sx;

    assign o_push = w_accept && !i_data.first && w_active && w_in_data
                  && r_byte_phase[1] && w_keep;
    assign o_pix.orow  = r_row_q;
    assign o_pix.ocol  = r_col_q;
    assign o_pix.pixel = {i_data.data_byte, r_green_hold, r_blue_hold};
    assign o_pix.last  = (r_file_row == i_cfg.src_height - 9'd1) && (r_pixel_column == r_clast);

    always_comb begin
        w_div_req.start = r_start;
        w_div_req.num   = '0;
        w_div_req.den   = 10'd1;
        unique case (r_state)
            S_ROW: begin
                w_div_req.num = {1'b0, w_f};
                w_div_req.den = {1'b0, w_sy};
            end
            S_COL: begin
                w_div_req.num = r_pixel_column;
                w_div_req.den = w_sx;
            end
            S_LAST: begin
                w_div_req.num = i_cfg.src_width - 10'd1;
                w_div_req.den = w_sx;
            end
            S_IDLE, S_MUL: begin
            end
            default: begin
            end
        endcase
    end

    bdfw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_start          <= 1'b0;
            r_header_count   <= '0;
            r_row_byte_count <= '0;
            r_file_row       <= '0;
            r_blue_hold      <= '0;
            r_green_hold     <= '0;
            r_byte_phase     <= '0;
            r_pixel_column   <= '0;
            // quotients that match the reset register values, steps of one
            r_row_q          <= RST_SRC_HEIGHT - 9'd1;
            r_row_r          <= '0;
            r_col_q          <= '0;
            r_col_r          <= '0;
            r_jl             <= RST_SRC_WIDTH - 10'd1;
            r_clast          <= RST_SRC_WIDTH - 10'd1;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_wr) begin
                        r_state <= S_ROW;
                        r_start <= 1'b1;
                    end
                end
                S_ROW: begin
                    if (w_div_rsp.done) begin
                        r_row_q <= w_div_rsp.quot[8:0];
                        r_row_r <= w_div_rsp.rem[8:0];
                        r_state <= S_COL;
                        r_start <= 1'b1;
                    end
                end
                S_COL: begin
                    if (w_div_rsp.done) begin
                        r_col_q <= w_div_rsp.quot;
                        r_col_r <= w_div_rsp.rem;
                        r_state <= S_LAST;
                        r_start <= 1'b1;
                    end
                end
                S_LAST: begin
                    if (w_div_rsp.done) begin
                        r_jl    <= w_div_rsp.quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_clast <= w_clast_prod[9:0];
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_accept) begin
                if (i_data.first) begin
                    // new file: this byte is header byte zero
                    r_header_count   <= 6'd1;
                    r_row_byte_count <= '0;
                    r_file_row       <= '0;
                    r_blue_hold      <= '0;
                    r_green_hold     <= '0;
                    r_byte_phase     <= '0;
                    r_pixel_column   <= '0;
                    r_state          <= S_ROW;
                    r_start          <= 1'b1;
                end else if (r_header_count < HDR) begin
                    r_header_count <= r_header_count + 6'd1;
                end else if (w_active) begin
                    if (w_in_data) begin
                        case (r_byte_phase)
                            2'd0: begin
                                r_blue_hold  <= i_data.data_byte;
                                r_byte_phase <= 2'd1;
                            end
                            2'd1: begin
                                r_green_hold <= i_data.data_byte;
                                r_byte_phase <= 2'd2;
                            end
                            default: begin
                                r_byte_phase   <= 2'd0;
                                r_pixel_column <= r_pixel_column + 10'd1;
                                if (w_col_r_inc == w_sx) begin
                                    r_col_r <= '0;
                                    r_col_q <= r_col_q + 10'd1;
                                end else begin
                                    r_col_r <= w_col_r_inc;
                                end
                            end
                        endcase
                    end
                    if (w_rbc_inc >= w_row_len) begin
                        // end of padded row, image row moves up by one
                        r_row_byte_count <= '0;
                        r_file_row       <= r_file_row + 9'd1;
                        r_byte_phase     <= '0;
                        r_pixel_column   <= '0;
                        r_col_q          <= '0;
                        r_col_r          <= '0;
                        if (r_row_r == '0) begin
                            r_row_r <= w_sy - 9'd1;
                            r_row_q <= r_row_q - 9'd1;
                        end else begin
                            r_row_r <= r_row_r - 9'd1;
                        end
                    end else begin
                        r_row_byte_count <= w_rbc_inc;
                    end
                end
            end
        end
    end

    a_first_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.first) |=> (r_state == S_ROW))
        else $error("first byte did not start the quotient refresh");

endmodule

// ===== src/bdfw_back.sv =====
// screen placement: offset, clip, address multiply and output register
// depends on bdfw_pkg
module bdfw_back import bdfw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [9:0] i_pos_x,
    input  logic [8:0] i_pos_y,
    input  logic      i_q_valid,
    input  t_pix      i_pix,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    localparam logic [31:0] SW_U = 32'(SCREEN_WIDTH);
    localparam logic [31:0] SH_U = 32'(SCREEN_HEIGHT);

    logic        r_a_valid;
    logic        r_a_vis;
    logic [9:0]  r_a_sr;
    logic [10:0] r_a_sc;
    logic [23:0] r_a_pixel;
    logic        r_a_last;
    logic        r_b_valid;
    t_out_item   r_b_data;

    logic [9:0]  w_sr;
    logic [10:0] w_sc;
    logic        w_vis;
    logic        w_b_free;
    logic        w_a_go;
    logic        w_a_free;
    logic [31:0] w_addr;

    assign w_sr  = {1'b0, i_pos_y} + {1'b0, i_pix.orow};
    assign w_sc  = {1'b0, i_pos_x} + {1'b0, i_pix.ocol};
    assign w_vis = (32'(w_sc) < SW_U) && (32'(w_sr) < SH_U);

    assign w_b_free = !r_b_valid || !i_stall;
    // an off-screen pixel leaves stage a without a slot downstream
    assign w_a_go   = r_a_valid && (!r_a_vis || w_b_free);
    assign w_a_free = !r_a_valid || w_a_go;
    assign o_pop    = i_q_valid && w_a_free;

    assign w_addr = 32'(r_a_sr) * SW_U + 32'(r_a_sc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_valid <= i_q_valid;
            end
            if (w_b_free) begin
                r_b_valid <= w_a_go && r_a_vis;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free) begin
            r_a_vis   <= w_vis;
            r_a_sr    <= w_sr;
            r_a_sc    <= w_sc;
            r_a_pixel <= i_pix.pixel;
            r_a_last  <= i_pix.last;
        end
        if (w_b_free) begin
            r_b_data.write_address <= w_addr[18:0];
            r_b_data.pixel_value   <= r_a_pixel;
            r_b_data.last          <= r_a_last;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

// ===== src/bmp_decimating_framebuffer_writer.sv =====
// top level: configuration registers, byte parser, pixel queue, placement stage
// depends on bdfw_pkg, bdfw_front, bdfw_queue, bdfw_back
//
//  channel   direction  handshake                       payload
//  input     in         i_valid / o_stall               i_data  (t_in_item)
//  output    out        o_valid / i_stall               o_data  (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one byte per cycle while the pixel queue has room and no refresh runs; a kept
// pixel passes from its red byte through the queue, clip stage and address register.
// a configuration write or a byte with first set starts a quotient refresh
// on the serial divider: three divisions and one multiply, during which
// o_stall and !o_cfg_ready hold.
// reset is synchronous and needs no refresh; o_stall also rises while
// i_cfg_valid is high, and a stalled output lets the queue fill up.
module bmp_decimating_framebuffer_writer import bdfw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_cfg_fire;
    logic w_busy;
    logic w_push;
    t_pix w_push_pix;
    logic w_q_full;
    logic w_q_valid;
    t_pix w_q_pix;
    logic w_pop;

    assign o_cfg_ready = !w_busy;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= RST_SRC_WIDTH;
            r_cfg.src_height <= RST_SRC_HEIGHT;
            r_cfg.dst_width  <= RST_DST_WIDTH;
            r_cfg.dst_height <= RST_DST_HEIGHT;
            r_cfg.step_x     <= RST_STEP_X;
            r_cfg.step_y     <= RST_STEP_Y;
            r_cfg.pos_x      <= RST_POS_X;
            r_cfg.pos_y      <= RST_POS_Y;
        end else if (w_cfg_fire) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[9:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[8:0];
                REG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[9:0];
                REG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[8:0];
                REG_STEP_X:     r_cfg.step_x     <= i_cfg_data[9:0];
                REG_STEP_Y:     r_cfg.step_y     <= i_cfg_data[8:0];
                REG_POS_X:      r_cfg.pos_x      <= i_cfg_data[9:0];
                REG_POS_Y:      r_cfg.pos_y      <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    bdfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_wr    (w_cfg_fire),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_busy      (w_busy),
        .o_push      (w_push),
        .o_pix       (w_push_pix),
        .i_q_full    (w_q_full)
    );

    bdfw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pix   (w_push_pix),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_pix   (w_q_pix)
    );

    bdfw_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pos_x   (r_cfg.pos_x),
        .i_pos_y   (r_cfg.pos_y),
        .i_q_valid (w_q_valid),
        .i_pix     (w_q_pix),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule
